>>> src/wth_pkg.sv
// ----------------------------------------------------------------------------
// wth_pkg: shared types, constants and functions of the word tokenizer
// Token kinds, register map, reset values, the token record and the
// rotate-add hash step.
// ----------------------------------------------------------------------------
package wth_pkg;

  // Character, position and hash widths
  localparam int CharW = 16;
  localparam int PosW  = 16;
  localparam int HashW = 32;
  localparam int HashRot = 7;

  localparam logic [PosW-1:0] PosMax = '1;

  // Result queue depth (holds two full items worth of tokens)
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  // APB register map
  localparam int AddrW = 5;
  localparam int DataW = 32;

  typedef enum logic [2:0] {
    REG_CASE_SENSITIVE = 3'd0,
    REG_BREAK_ON_PUNCT = 3'd1,
    REG_BREAK_CHAR_A   = 3'd2,
    REG_BREAK_CHAR_B   = 3'd3,
    REG_BREAK_CHAR_C   = 3'd4,
    REG_BREAK_CHAR_D   = 3'd5
  } reg_idx_e;

  // Register reset values: comma, period, semicolon, colon
  localparam logic [CharW-1:0] BreakCharARst = 16'd44;
  localparam logic [CharW-1:0] BreakCharBRst = 16'd46;
  localparam logic [CharW-1:0] BreakCharCRst = 16'd59;
  localparam logic [CharW-1:0] BreakCharDRst = 16'd58;

  // ASCII constants used for classification and case folding
  localparam logic [CharW-1:0] ChSpace    = 16'd32;
  localparam logic [CharW-1:0] ChTab      = 16'd9;
  localparam logic [CharW-1:0] ChCr       = 16'd13;
  localparam logic [CharW-1:0] ChLowerA   = 16'd97;
  localparam logic [CharW-1:0] ChLowerZ   = 16'd122;
  localparam logic [CharW-1:0] CaseOffset = 16'd32;

  typedef enum logic [1:0] {
    KIND_SPACE = 2'd0,
    KIND_WORD  = 2'd1,
    KIND_BREAK = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [PosW-1:0]   start;
    logic [PosW-1:0]   stop;
    logic [HashW-1:0]  hash;
    logic              run_last;
    logic              line_done;
  } token_t;

  // One hash step: h + c + rol(h, 7), modulo 2^32
  function automatic logic [HashW-1:0] hash_add(logic [HashW-1:0] h,
                                                logic [CharW-1:0] c);
    logic [HashW-1:0] rot;
    rot = {h[HashW-1-HashRot:0], h[HashW-1:HashW-HashRot]};
    return h + {{(HashW-CharW){1'b0}}, c} + rot;
  endfunction

  // Position plus one, sticking at the top
  function automatic logic [PosW-1:0] sat_next(logic [PosW-1:0] p);
    return (p == PosMax) ? PosMax : p + 1'b1;
  endfunction

endpackage

>>> src/wth_char_if.sv
// ----------------------------------------------------------------------------
// wth_char_if: character input channel
// One UTF-16 code unit per transaction, with the end-of-line flag.
// ----------------------------------------------------------------------------
interface wth_char_if;
  logic        valid;
  logic        ready;
  logic [15:0] char_code;
  logic        line_last;

  modport source (output valid, output char_code, output line_last, input ready);
  modport sink   (input valid, input char_code, input line_last, output ready);
endinterface

>>> src/wth_token_if.sv
// ----------------------------------------------------------------------------
// wth_token_if: token output channel
// One token per transaction: kind, span, hash and end markers.
// ----------------------------------------------------------------------------
interface wth_token_if;
  logic        valid;
  logic        ready;
  logic [1:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_end;
  logic [31:0] token_hash;
  logic        run_last;
  logic        line_done;

  modport source (output valid, output token_kind, output token_start,
                  output token_end, output token_hash, output run_last,
                  output line_done, input ready);
  modport sink   (input valid, input token_kind, input token_start,
                  input token_end, input token_hash, input run_last,
                  input line_done, output ready);
endinterface

>>> src/word_tokenizer_hash_top.sv
// Word tokenizer with rotate-add hash. Takes one code unit per cycle and
// produces zero, one or two tokens for it (whitespace run, word, or a single
// break character), each with start, exclusive end and a 32-bit hash. The
// tokenizer state is updated in the cycle the character is accepted and the
// resulting tokens go into a 4-entry result queue that drains one token per
// cycle while the token side is ready; the input is ready whenever the queue
// has room for two tokens, so a character is taken every cycle as long as
// the token side keeps up. Tokens are registered in the queue before they
// reach the output. A character with line_last set flushes the pending token
// and restarts positions at 0. Registers are written through APB with no
// wait states and should only change while the block is idle.
// ----------------------------------------------------------------------------
// word_tokenizer_hash_top: line tokenizer with per-token hash
// Classification, hash update and token assembly feeding a result queue.
// ----------------------------------------------------------------------------
module word_tokenizer_hash_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  wth_char_if.sink                   char_i,
  wth_token_if.source                token_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wth_pkg::AddrW-1:0]  paddr,
  input  logic [wth_pkg::DataW-1:0]  pwdata,
  output logic [wth_pkg::DataW-1:0]  prdata,
  output logic                       pready
);

  // Configuration registers
  logic                            case_sens_q;
  logic                            break_en_q;
  logic [wth_pkg::CharW-1:0]       brk_a_q, brk_b_q, brk_c_q, brk_d_q;
  logic [2:0]                      reg_idx;
  logic                            cfg_wr;

  // Tokenizer state
  logic                            in_word_q, in_word_d;
  logic                            pend_q, pend_d;
  logic [wth_pkg::PosW-1:0]        begin_q, begin_d;
  logic [wth_pkg::PosW-1:0]        pos_q, pos_d;
  logic [wth_pkg::HashW-1:0]       hash_q, hash_d;

  // Per-character decode
  logic [wth_pkg::CharW-1:0]       c, hc;
  logic                            last, sp, br, ext, emit_a, emit_b, emit_c;
  logic [wth_pkg::HashW-1:0]       h_new;
  logic [wth_pkg::PosW-1:0]        pos_nxt, run_start;
  wth_pkg::token_t                 tok_a, tok_b, tok_c, res0, res1;
  logic [1:0]                      n_res;

  // Result queue
  wth_pkg::token_t                 q_mem_q [wth_pkg::QueueDepth];
  logic [wth_pkg::QueuePtrW-1:0]   wr_ptr_q, rd_ptr_q, wr_ptr1;
  logic [wth_pkg::QueueCntW-1:0]   cnt_q;
  logic                            push, pop;
  wth_pkg::token_t                 head;

  // ---------------- APB register port ----------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[wth_pkg::AddrW-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      case_sens_q <= 1'b1;
      break_en_q  <= 1'b0;
      brk_a_q     <= wth_pkg::BreakCharARst;
      brk_b_q     <= wth_pkg::BreakCharBRst;
      brk_c_q     <= wth_pkg::BreakCharCRst;
      brk_d_q     <= wth_pkg::BreakCharDRst;
    end else if (cfg_wr) begin
      case (reg_idx)
        wth_pkg::REG_CASE_SENSITIVE: case_sens_q <= pwdata[0];
        wth_pkg::REG_BREAK_ON_PUNCT: break_en_q  <= pwdata[0];
        wth_pkg::REG_BREAK_CHAR_A:   brk_a_q     <= pwdata[wth_pkg::CharW-1:0];
        wth_pkg::REG_BREAK_CHAR_B:   brk_b_q     <= pwdata[wth_pkg::CharW-1:0];
        wth_pkg::REG_BREAK_CHAR_C:   brk_c_q     <= pwdata[wth_pkg::CharW-1:0];
        wth_pkg::REG_BREAK_CHAR_D:   brk_d_q     <= pwdata[wth_pkg::CharW-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux
  always_comb begin
    prdata = '0;
    case (reg_idx)
      wth_pkg::REG_CASE_SENSITIVE: prdata[0] = case_sens_q;
      wth_pkg::REG_BREAK_ON_PUNCT: prdata[0] = break_en_q;
      wth_pkg::REG_BREAK_CHAR_A:   prdata[wth_pkg::CharW-1:0] = brk_a_q;
      wth_pkg::REG_BREAK_CHAR_B:   prdata[wth_pkg::CharW-1:0] = brk_b_q;
      wth_pkg::REG_BREAK_CHAR_C:   prdata[wth_pkg::CharW-1:0] = brk_c_q;
      wth_pkg::REG_BREAK_CHAR_D:   prdata[wth_pkg::CharW-1:0] = brk_d_q;
      default: prdata = '0;
    endcase
  end

  // ---------------- Character classification ----------------
  assign c    = char_i.char_code;
  assign last = char_i.line_last;

  always_comb begin
    sp = c inside {[wth_pkg::ChTab:wth_pkg::ChCr], wth_pkg::ChSpace};
    br = !sp && break_en_q &&
         (c == brk_a_q || c == brk_b_q || c == brk_c_q || c == brk_d_q);
    // Fold ASCII lower case for hashing when case-insensitive
    if (!case_sens_q && (c inside {[wth_pkg::ChLowerA:wth_pkg::ChLowerZ]})) begin
      hc = c - wth_pkg::CaseOffset;
    end else begin
      hc = c;
    end
  end

  // ---------------- Token assembly ----------------
  always_comb begin
    pos_nxt = wth_pkg::sat_next(pos_q);
    // Character continues the pending run
    ext = pend_q && ((!in_word_q && sp) || (in_word_q && !sp && !br));
    // Character closes the pending run
    emit_a = pend_q && ((!in_word_q && !sp) || (in_word_q && (sp || br)));
    emit_b = br;
    emit_c = last && !br;

    h_new     = wth_pkg::hash_add(ext ? hash_q : '0, hc);
    run_start = ext ? begin_q : pos_q;

    tok_a.kind      = in_word_q ? wth_pkg::KIND_WORD : wth_pkg::KIND_SPACE;
    tok_a.start     = begin_q;
    tok_a.stop      = pos_q;
    tok_a.hash      = hash_q;
    tok_a.run_last  = 1'b0;
    tok_a.line_done = 1'b0;

    // A break token's hash is one step from zero, i.e. the folded code
    tok_b.kind      = wth_pkg::KIND_BREAK;
    tok_b.start     = pos_q;
    tok_b.stop      = pos_nxt;
    tok_b.hash      = {{(wth_pkg::HashW-wth_pkg::CharW){1'b0}}, hc};
    tok_b.run_last  = 1'b0;
    tok_b.line_done = 1'b0;

    // End-of-line flush of the run this character leaves pending
    tok_c.kind      = sp ? wth_pkg::KIND_SPACE : wth_pkg::KIND_WORD;
    tok_c.start     = run_start;
    tok_c.stop      = pos_nxt;
    tok_c.hash      = h_new;
    tok_c.run_last  = 1'b0;
    tok_c.line_done = 1'b0;

    // Order: closed run, then break, then flush
    res0  = emit_a ? tok_a : (emit_b ? tok_b : tok_c);
    res1  = (emit_a && emit_b) ? tok_b : tok_c;
    n_res = 2'(emit_a) + 2'(emit_b) + 2'(emit_c);

    if (n_res == 2'd1) begin
      res0.run_last  = 1'b1;
      res0.line_done = last;
    end
    res1.run_last  = 1'b1;
    res1.line_done = last;

    // Next tokenizer state
    if (last) begin
      in_word_d = 1'b0;
      pend_d    = 1'b0;
      begin_d   = '0;
      hash_d    = '0;
      pos_d     = '0;
    end else begin
      in_word_d = !sp;
      pend_d    = !br;
      begin_d   = run_start;
      hash_d    = h_new;
      pos_d     = pos_nxt;
    end
  end

  // ---------------- Tokenizer state registers ----------------
  assign push = char_i.valid && char_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_word_q <= 1'b0;
      pend_q    <= 1'b0;
      begin_q   <= '0;
      pos_q     <= '0;
      hash_q    <= '0;
    end else if (push) begin
      in_word_q <= in_word_d;
      pend_q    <= pend_d;
      begin_q   <= begin_d;
      pos_q     <= pos_d;
      hash_q    <= hash_d;
    end
  end

  // ---------------- Result queue ----------------
  // Room for two tokens lets every character in regardless of its count
  assign char_i.ready = (cnt_q <= wth_pkg::QueueCntW'(wth_pkg::QueueDepth - 2));
  assign pop          = token_o.valid && token_o.ready;
  assign wr_ptr1      = wr_ptr_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (push && (n_res != 2'd0)) begin
      q_mem_q[wr_ptr_q] <= res0;
    end
    if (push && (n_res == 2'd2)) begin
      q_mem_q[wr_ptr1] <= res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + wth_pkg::QueuePtrW'(n_res);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + (push ? wth_pkg::QueueCntW'(n_res) : '0)
                     - wth_pkg::QueueCntW'(pop);
    end
  end

  // Output from the queue head
  assign head                = q_mem_q[rd_ptr_q];
  assign token_o.valid       = (cnt_q != '0);
  assign token_o.token_kind  = head.kind;
  assign token_o.token_start = head.start;
  assign token_o.token_end   = head.stop;
  assign token_o.token_hash  = head.hash;
  assign token_o.run_last    = head.run_last;
  assign token_o.line_done   = head.line_done;

endmodule
